// ===== rtl/cde_pkg.sv =====
// ----------------------------------------------------------------------------
// cde_pkg
// Shared types and constants of the circular deque engine: command codes,
// field widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package cde_pkg;

   localparam int CMD_W       = 3;
   localparam int FIELD_BYTES = 20;
   localparam int FIELD_W     = FIELD_BYTES * 8;
   localparam int COUNT_W     = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_CLEAR      = 3'd4,
      CMD_STATUS     = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_ACCEPT = 2'b01,
      ST_READ   = 2'b10
   } state_type;

endpackage

// ===== rtl/cde_chan_if.sv =====
// ----------------------------------------------------------------------------
// cde_req_if / cde_rsp_if
// Valid/ready channels of the circular deque engine: the command channel
// and the result channel.
// ----------------------------------------------------------------------------
interface cde_req_if;
   logic                       valid;
   logic                       ready;
   logic [cde_pkg::CMD_W-1:0]  command;
   logic [63:0]                text_bytes_0_7;
   logic [63:0]                text_bytes_8_15;
   logic [31:0]                text_bytes_16_19;

   modport source (output valid, command, text_bytes_0_7, text_bytes_8_15,
                   text_bytes_16_19, input ready);
   modport sink   (input valid, command, text_bytes_0_7, text_bytes_8_15,
                   text_bytes_16_19, output ready);
endinterface

interface cde_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         status;
   logic [63:0]                  popped_bytes_0_7;
   logic [63:0]                  popped_bytes_8_15;
   logic [31:0]                  popped_bytes_16_19;
   logic [cde_pkg::COUNT_W-1:0]  entry_count;
   logic                         is_empty;
   logic                         is_full;

   modport source (output valid, status, popped_bytes_0_7, popped_bytes_8_15,
                   popped_bytes_16_19, entry_count, is_empty, is_full,
                   input ready);
   modport sink   (input valid, status, popped_bytes_0_7, popped_bytes_8_15,
                   popped_bytes_16_19, entry_count, is_empty, is_full,
                   output ready);
endinterface

// ===== rtl/circular_deque_engine_unit.sv =====
// ----------------------------------------------------------------------------
// circular_deque_engine_unit
// Double-ended queue of short texts held in a ring memory of SLOTS entries.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on req_ch (push back, push front, pop front, pop back,
//   clear, status only) and each one returns exactly one result on rsp_ch
//   with the status, the popped text, the entry count and the empty and
//   full flags after the command. One slot always stays free, so the ring
//   holds at most SLOTS-1 texts.
//   A result that needs no memory read is shown in the cycle after the
//   request transfer; a successful pop first reads its text into the
//   registered read port of the text memory and then into the result
//   register, and req_ch.ready stays low in ST_READ meanwhile. Otherwise
//   one command per cycle is taken while the receiver takes each result.
//   A new command is taken while a finished result is being transferred.
//   When the receiver stalls, the result register holds and req_ch.ready
//   stays low until the result is taken.
//   Reset empties the queue (both indices at SLOTS-1); the text memory is
//   not cleared, since no pop can reach an entry that was never written.
// ----------------------------------------------------------------------------
module circular_deque_engine_unit #(
   parameter int SLOTS      = 16,
   parameter int TEXT_BYTES = 20
) (
   input  logic        clock,
   input  logic        reset,
   cde_req_if.sink     req_ch,
   cde_rsp_if.source   rsp_ch
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TW    = TEXT_BYTES * 8;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

   function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
      return (i == LAST) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
      return (i == '0) ? LAST : i - 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] count_of(input logic [IDX_W-1:0] f,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] wide;
      if (b >= f) begin
         wide = {1'b0, b} - {1'b0, f};
      end else begin
         wide = {1'b0, b} + (IDX_W+1)'(SLOTS) - {1'b0, f};
      end
      return wide[IDX_W-1:0];
   endfunction

   // Text memory and its registered read port.
   logic [TW-1:0]          text_mem [SLOTS];
   logic [TW-1:0]          rd_data_ff;

   logic [IDX_W-1:0]       front_ff, front_in;
   logic [IDX_W-1:0]       back_ff, back_in;
   cde_pkg::state_type     state_ff, state_in;

   logic                   rsp_valid_ff;
   logic                   rsp_status_ff;
   logic [cde_pkg::FIELD_W-1:0] rsp_text_ff;
   logic [cde_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                   rsp_empty_ff;
   logic                   rsp_full_ff;

   logic                   accept;
   logic                   cur_empty, cur_full;
   logic                   fail, pop_ok;
   logic                   wr_en, rd_en;
   logic [IDX_W-1:0]       wr_addr, rd_addr;
   logic [TW-1:0]          clean_text;
   logic [cde_pkg::FIELD_W-1:0] raw_text;
   cde_pkg::cmd_type       cmd;

   assign req_ch.ready = (state_ff == cde_pkg::ST_ACCEPT) &&
                         (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign cmd          = cde_pkg::cmd_type'(req_ch.command);
   assign raw_text     = {req_ch.text_bytes_16_19, req_ch.text_bytes_8_15,
                          req_ch.text_bytes_0_7};

   assign cur_empty = (front_ff == back_ff);
   assign cur_full  = (front_ff == step_up(back_ff));

   // The text ends at its first zero byte and at TEXT_BYTES; all later
   // bytes are stored as zero.
   always_comb begin
      logic                        ended;
      logic [cde_pkg::FIELD_W-1:0] kept;
      ended = 1'b0;
      kept  = '0;
      for (int i = 0; i < cde_pkg::FIELD_BYTES; i++) begin
         if ((i >= TEXT_BYTES) || (raw_text[i*8 +: 8] == 8'h00)) begin
            ended = 1'b1;
         end
         if (!ended) begin
            kept[i*8 +: 8] = raw_text[i*8 +: 8];
         end
      end
      clean_text = kept[TW-1:0];
   end

   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      fail     = 1'b0;
      pop_ok   = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      wr_addr  = back_ff;
      rd_addr  = back_ff;
      if (accept) begin
         unique case (cmd)
            cde_pkg::CMD_PUSH_BACK: begin
               if (cur_full) begin
                  fail = 1'b1;
               end else begin
                  back_in = step_up(back_ff);
                  wr_en   = 1'b1;
                  wr_addr = step_up(back_ff);
               end
            end
            cde_pkg::CMD_PUSH_FRONT: begin
               if (cur_full) begin
                  fail = 1'b1;
               end else begin
                  front_in = step_down(front_ff);
                  wr_en    = 1'b1;
                  wr_addr  = front_ff;
               end
            end
            cde_pkg::CMD_POP_FRONT: begin
               if (cur_empty) begin
                  fail = 1'b1;
               end else begin
                  front_in = step_up(front_ff);
                  rd_en    = 1'b1;
                  rd_addr  = step_up(front_ff);
                  pop_ok   = 1'b1;
               end
            end
            cde_pkg::CMD_POP_BACK: begin
               if (cur_empty) begin
                  fail = 1'b1;
               end else begin
                  back_in = step_down(back_ff);
                  rd_en   = 1'b1;
                  rd_addr = back_ff;
                  pop_ok  = 1'b1;
               end
            end
            cde_pkg::CMD_CLEAR: begin
               if (cur_empty) begin
                  fail = 1'b1;
               end else begin
                  front_in = LAST;
                  back_in  = LAST;
               end
            end
            cde_pkg::CMD_STATUS: begin
            end
            default: begin
               fail = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cde_pkg::ST_ACCEPT: begin
            if (accept && pop_ok) begin
               state_in = cde_pkg::ST_READ;
            end
         end
         cde_pkg::ST_READ: begin
            state_in = cde_pkg::ST_ACCEPT;
         end
         default: begin
            state_in = cde_pkg::ST_ACCEPT;
         end
      endcase
   end

   // Only one command is in flight per edge, so a write and a read never
   // meet on the same entry in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         text_mem[wr_addr] <= clean_text;
      end
      if (rd_en) begin
         rd_data_ff <= text_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= LAST;
         back_ff      <= LAST;
         state_ff     <= cde_pkg::ST_ACCEPT;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff <= front_in;
         back_ff  <= back_in;
         state_ff <= state_in;
         if (accept) begin
            rsp_valid_ff <= !pop_ok;
         end else if (state_ff == cde_pkg::ST_READ) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // The result register is free at every accepted transfer, so the flags
   // are loaded then; a pop adds its text in the cycle after, from ST_READ.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= fail;
         rsp_count_ff  <= cde_pkg::COUNT_W'(count_of(front_in, back_in));
         rsp_empty_ff  <= (front_in == back_in);
         rsp_full_ff   <= (front_in == step_up(back_in));
         rsp_text_ff   <= '0;
      end else if (state_ff == cde_pkg::ST_READ) begin
         rsp_text_ff   <= cde_pkg::FIELD_W'(rd_data_ff);
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.status             = rsp_status_ff;
   assign rsp_ch.popped_bytes_0_7   = rsp_text_ff[63:0];
   assign rsp_ch.popped_bytes_8_15  = rsp_text_ff[127:64];
   assign rsp_ch.popped_bytes_16_19 = rsp_text_ff[159:128];
   assign rsp_ch.entry_count        = rsp_count_ff;
   assign rsp_ch.is_empty           = rsp_empty_ff;
   assign rsp_ch.is_full            = rsp_full_ff;

endmodule
